FILE: sv/swq_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the semaphore wait queue table.
package swq_pkg;

   localparam int DEF_MAX_PROCESSES = 16;
   localparam int DEF_KEY_BITS      = 32;
   localparam int SEM_KEY_W         = 32;
   localparam int PROC_ID_W         = 4;

   typedef enum logic [1:0] {
      OP_BLOCK       = 2'd0,
      OP_REMOVE_HEAD = 2'd1,
      OP_REMOVE_PROC = 2'd2,
      OP_PEEK        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // Which value goes out as result_proc.
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_HEAD = 2'd1,
      KIND_PROC = 2'd2
   } rsp_kind_type;

   // Address select for the next-link memory read port.
   typedef enum logic [1:0] {
      NSEL_TAIL = 2'd0,
      NSEL_HEAD = 2'd1,
      NSEL_PROC = 2'd2
   } nsel_type;

   // Table update for the datapath to carry out.
   typedef enum logic [2:0] {
      WR_NONE        = 3'd0,
      WR_LINK1       = 3'd1,
      WR_LINK2       = 3'd2,
      WR_NEW         = 3'd3,
      WR_UNHEAD      = 3'd4,
      WR_UNLINK      = 3'd5,
      WR_UNLINK_TAIL = 3'd6,
      WR_FREE        = 3'd7
   } wr_type;

   typedef struct packed {
      op_type                 op;
      logic [SEM_KEY_W-1:0]   sem_key;
      logic [PROC_ID_W-1:0]   proc_id;
   } req_word_type;

   typedef struct packed {
      status_type             status;
      logic                   result_valid;
      logic [PROC_ID_W-1:0]   result_proc;
   } rsp_word_type;

   typedef struct packed {
      logic         load_req;
      logic         skey_load;
      logic         scan_cmp;
      logic         scan_inc;
      logic         hit;
      logic         h_load;
      logic         walk_clr;
      logic         walk_inc;
      nsel_type     nsel;
      wr_type       wr;
      logic         rsp_load;
      status_type   rsp_status;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic pid_bad;
      logic match;
      logic scan_last;
      logic free_any;
      logic h_eq_t;
      logic cur_is_p;
      logic cur_is_t;
      logic walk_last;
      logic p_is_t;
      logic nx_is_p;
   } stat_type;

endpackage

FILE: sv/swq_datapath.sv
`timescale 1ns / 1ps
// Datapath: descriptor and link memories, working registers, response register.
module swq_datapath #(
   parameter int MAX_PROCESSES = swq_pkg::DEF_MAX_PROCESSES,
   parameter int KEY_BITS      = swq_pkg::DEF_KEY_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swq_pkg::req_word_type req_data,
   input  swq_pkg::cmd_type      cmd,
   output swq_pkg::stat_type     stat,
   output swq_pkg::rsp_word_type rsp_data
);

   localparam int IW = $clog2(MAX_PROCESSES);

   // memories
   logic [KEY_BITS-1:0] dkey_mem  [MAX_PROCESSES];
   logic [IW-1:0]       dtail_mem [MAX_PROCESSES];
   logic [IW-1:0]       pnext_mem [MAX_PROCESSES];
   logic [IW-1:0]       pprev_mem [MAX_PROCESSES];
   logic [KEY_BITS-1:0] pkey_mem  [MAX_PROCESSES];

   logic [MAX_PROCESSES-1:0] in_use_ff, in_use_in;

   // working registers
   logic [swq_pkg::PROC_ID_W-1:0] pid_ff;
   logic [KEY_BITS-1:0]          skey_ff;
   logic [IW-1:0]                cnt_ff, d_ff, t_ff, h_ff, free_ff, walk_ff;
   logic                         free_found_ff;

   // registered read data
   logic [KEY_BITS-1:0] dkey_rd_ff, pkey_rd_ff;
   logic [IW-1:0]       dtail_rd_ff, pnext_rd_ff, pprev_rd_ff;

   swq_pkg::rsp_word_type rsp_ff;

   logic [IW-1:0] p_idx, n_raddr;

   // write ports
   logic                dkey_we, dtail_we, pnext_we, pprev_we, pkey_we;
   logic [IW-1:0]       dkey_wa, dtail_wa, pnext_wa, pprev_wa;
   logic [KEY_BITS-1:0] dkey_wd;
   logic [IW-1:0]       dtail_wd, pnext_wd, pprev_wd;

   assign p_idx = IW'(pid_ff);

   always_comb begin
      case (cmd.nsel)
         swq_pkg::NSEL_TAIL: n_raddr = t_ff;
         swq_pkg::NSEL_HEAD: n_raddr = h_ff;
         swq_pkg::NSEL_PROC: n_raddr = p_idx;
         default:            n_raddr = t_ff;
      endcase
   end

   // status toward the controller
   always_comb begin
      stat.pid_bad   = 32'(req_data.proc_id) >= 32'(MAX_PROCESSES);
      stat.match     = in_use_ff[cnt_ff] && (dkey_rd_ff == skey_ff);
      stat.scan_last = cnt_ff == IW'(MAX_PROCESSES - 1);
      stat.free_any  = free_found_ff || !in_use_ff[cnt_ff];
      stat.h_eq_t    = pnext_rd_ff == t_ff;
      stat.cur_is_p  = h_ff == p_idx;
      stat.cur_is_t  = h_ff == t_ff;
      stat.walk_last = walk_ff == IW'(MAX_PROCESSES - 1);
      stat.p_is_t    = p_idx == t_ff;
      stat.nx_is_p   = pnext_rd_ff == p_idx;
   end

   // decode of the table update
   always_comb begin
      dkey_we  = 1'b0;  dkey_wa  = free_ff; dkey_wd  = skey_ff;
      dtail_we = 1'b0;  dtail_wa = d_ff;    dtail_wd = p_idx;
      pnext_we = 1'b0;  pnext_wa = p_idx;   pnext_wd = p_idx;
      pprev_we = 1'b0;  pprev_wa = p_idx;   pprev_wd = p_idx;
      pkey_we  = 1'b0;
      in_use_in = in_use_ff;
      unique case (cmd.wr)
         swq_pkg::WR_NONE: begin
         end
         swq_pkg::WR_LINK1: begin
            pprev_we = 1'b1; pprev_wa = h_ff;
            pnext_we = 1'b1; pnext_wd = h_ff;
         end
         swq_pkg::WR_LINK2: begin
            pprev_we = 1'b1; pprev_wd = t_ff;
            pnext_we = 1'b1; pnext_wa = t_ff;
            dtail_we = 1'b1;
            pkey_we  = 1'b1;
         end
         swq_pkg::WR_NEW: begin
            in_use_in[free_ff] = 1'b1;
            dkey_we  = 1'b1;
            dtail_we = 1'b1; dtail_wa = free_ff;
            pkey_we  = 1'b1;
            pnext_we = 1'b1;
            pprev_we = 1'b1;
         end
         swq_pkg::WR_UNHEAD: begin
            pnext_we = 1'b1; pnext_wa = t_ff;        pnext_wd = pnext_rd_ff;
            pprev_we = 1'b1; pprev_wa = pnext_rd_ff; pprev_wd = t_ff;
         end
         swq_pkg::WR_UNLINK, swq_pkg::WR_UNLINK_TAIL: begin
            pnext_we = 1'b1; pnext_wa = pprev_rd_ff; pnext_wd = pnext_rd_ff;
            pprev_we = 1'b1; pprev_wa = pnext_rd_ff; pprev_wd = pprev_rd_ff;
            dtail_we = cmd.wr == swq_pkg::WR_UNLINK_TAIL;
            dtail_wd = pprev_rd_ff;
         end
         swq_pkg::WR_FREE: begin
            in_use_in[d_ff] = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (dkey_we)  dkey_mem[dkey_wa]   <= dkey_wd;
      if (dtail_we) dtail_mem[dtail_wa] <= dtail_wd;
      if (pnext_we) pnext_mem[pnext_wa] <= pnext_wd;
      if (pprev_we) pprev_mem[pprev_wa] <= pprev_wd;
      if (pkey_we)  pkey_mem[p_idx]     <= skey_ff;
      dkey_rd_ff  <= dkey_mem[cnt_ff];
      dtail_rd_ff <= dtail_mem[cnt_ff];
      pnext_rd_ff <= pnext_mem[n_raddr];
      pprev_rd_ff <= pprev_mem[p_idx];
      pkey_rd_ff  <= pkey_mem[p_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         pid_ff        <= req_data.proc_id;
         skey_ff       <= KEY_BITS'(req_data.sem_key);
         cnt_ff        <= '0;
         free_found_ff <= 1'b0;
      end
      if (cmd.skey_load) skey_ff <= pkey_rd_ff;
      if (cmd.scan_cmp && !free_found_ff && !in_use_ff[cnt_ff]) begin
         free_ff       <= cnt_ff;
         free_found_ff <= 1'b1;
      end
      if (cmd.scan_inc) cnt_ff <= cnt_ff + 1'b1;
      if (cmd.hit) begin
         d_ff <= cnt_ff;
         t_ff <= dtail_rd_ff;
      end
      if (cmd.h_load)   h_ff <= pnext_rd_ff;
      if (cmd.walk_clr) walk_ff <= '0;
      if (cmd.walk_inc) walk_ff <= walk_ff + 1'b1;
      if (cmd.rsp_load) begin
         rsp_ff.status <= cmd.rsp_status;
         case (cmd.rsp_kind)
            swq_pkg::KIND_HEAD: begin
               rsp_ff.result_valid <= 1'b1;
               rsp_ff.result_proc  <= swq_pkg::PROC_ID_W'(h_ff);
            end
            swq_pkg::KIND_PROC: begin
               rsp_ff.result_valid <= 1'b1;
               rsp_ff.result_proc  <= pid_ff;
            end
            default: begin
               rsp_ff.result_valid <= 1'b0;
               rsp_ff.result_proc  <= '0;
            end
         endcase
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: sv/swq_control.sv
`timescale 1ns / 1ps
// Controller state machine: sequences lookup, link walk and updates per op.
module swq_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  swq_pkg::op_type   req_op,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  swq_pkg::stat_type stat,
   output swq_pkg::cmd_type  cmd
);

   typedef enum logic [17:0] {
      S_IDLE   = 18'h00001,
      S_PKEY   = 18'h00002,
      S_PKEYLD = 18'h00004,
      S_SRD    = 18'h00008,
      S_SCMP   = 18'h00010,
      S_HRD    = 18'h00020,
      S_HLD    = 18'h00040,
      S_LNK1   = 18'h00080,
      S_LNK2   = 18'h00100,
      S_NEW    = 18'h00200,
      S_NRD    = 18'h00400,
      S_NLD    = 18'h00800,
      S_WCHK   = 18'h01000,
      S_WRD    = 18'h02000,
      S_WLD    = 18'h04000,
      S_PRD    = 18'h08000,
      S_PLD    = 18'h10000,
      S_RESP   = 18'h20000
   } state_type;

   state_type             state_ff, state_in;
   swq_pkg::op_type       op_ff, op_in;
   swq_pkg::status_type   st_ff, st_in;
   swq_pkg::rsp_kind_type kind_ff, kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      st_in        = st_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.nsel     = swq_pkg::NSEL_TAIL;
      cmd.wr       = swq_pkg::WR_NONE;
      cmd.rsp_status = st_ff;
      cmd.rsp_kind   = kind_ff;
      req_stall    = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               op_in        = req_op;
               if ((req_op == swq_pkg::OP_BLOCK || req_op == swq_pkg::OP_REMOVE_PROC)
                   && stat.pid_bad) begin
                  st_in    = swq_pkg::ST_NOT_FOUND;
                  kind_in  = swq_pkg::KIND_NONE;
                  state_in = S_RESP;
               end else if (req_op == swq_pkg::OP_REMOVE_PROC) begin
                  state_in = S_PKEY;
               end else begin
                  state_in = S_SRD;
               end
            end
         end
         S_PKEY:   state_in = S_PKEYLD;
         S_PKEYLD: begin
            cmd.skey_load = 1'b1;
            state_in      = S_SRD;
         end
         S_SRD:    state_in = S_SCMP;
         S_SCMP: begin
            cmd.scan_cmp = 1'b1;
            if (stat.match) begin
               cmd.hit  = 1'b1;
               state_in = S_HRD;
            end else if (stat.scan_last) begin
               kind_in = swq_pkg::KIND_NONE;
               if (op_ff == swq_pkg::OP_BLOCK && stat.free_any) begin
                  state_in = S_NEW;
               end else begin
                  st_in    = (op_ff == swq_pkg::OP_BLOCK) ? swq_pkg::ST_FULL
                                                           : swq_pkg::ST_NOT_FOUND;
                  state_in = S_RESP;
               end
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_SRD;
            end
         end
         S_HRD: begin
            cmd.nsel = swq_pkg::NSEL_TAIL;
            state_in = S_HLD;
         end
         S_HLD: begin
            cmd.h_load = 1'b1;
            st_in      = swq_pkg::ST_OK;
            kind_in    = swq_pkg::KIND_HEAD;
            unique case (op_ff)
               swq_pkg::OP_BLOCK: state_in = S_LNK1;
               swq_pkg::OP_PEEK:  state_in = S_RESP;
               swq_pkg::OP_REMOVE_HEAD: begin
                  if (stat.h_eq_t) begin
                     cmd.wr   = swq_pkg::WR_FREE;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_NRD;
                  end
               end
               swq_pkg::OP_REMOVE_PROC: begin
                  cmd.walk_clr = 1'b1;
                  state_in     = S_WCHK;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_LNK1: begin
            cmd.wr   = swq_pkg::WR_LINK1;
            state_in = S_LNK2;
         end
         S_LNK2: begin
            cmd.wr   = swq_pkg::WR_LINK2;
            st_in    = swq_pkg::ST_OK;
            kind_in  = swq_pkg::KIND_NONE;
            state_in = S_RESP;
         end
         S_NEW: begin
            cmd.wr   = swq_pkg::WR_NEW;
            st_in    = swq_pkg::ST_OK;
            state_in = S_RESP;
         end
         S_NRD: begin
            cmd.nsel = swq_pkg::NSEL_HEAD;
            state_in = S_NLD;
         end
         S_NLD: begin
            cmd.wr   = swq_pkg::WR_UNHEAD;
            state_in = S_RESP;
         end
         S_WCHK: begin
            if (stat.cur_is_p) begin
               state_in = S_PRD;
            end else if (stat.cur_is_t || stat.walk_last) begin
               st_in    = swq_pkg::ST_NOT_FOUND;
               kind_in  = swq_pkg::KIND_NONE;
               state_in = S_RESP;
            end else begin
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            cmd.nsel = swq_pkg::NSEL_HEAD;
            state_in = S_WLD;
         end
         S_WLD: begin
            cmd.h_load   = 1'b1;
            cmd.walk_inc = 1'b1;
            state_in     = S_WCHK;
         end
         S_PRD: begin
            cmd.nsel = swq_pkg::NSEL_PROC;
            state_in = S_PLD;
         end
         S_PLD: begin
            if (stat.p_is_t && stat.nx_is_p) cmd.wr = swq_pkg::WR_FREE;
            else if (stat.p_is_t)            cmd.wr = swq_pkg::WR_UNLINK_TAIL;
            else                             cmd.wr = swq_pkg::WR_UNLINK;
            st_in    = swq_pkg::ST_OK;
            kind_in  = swq_pkg::KIND_PROC;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      st_ff   <= st_in;
      kind_ff <= kind_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/semaphore_wait_queue_table.sv
`timescale 1ns / 1ps
// Semaphore wait queue table: a pool of MAX_PROCESSES descriptors, each a
// keyed FIFO of blocked process ids, served one request word at a time.
// Each request word gives exactly one response word. Timing is data dependent:
// the key lookup walks the descriptor table in index order, with one
// registered read of the key memory and one compare per descriptor visited,
// and stops at a hit or runs through every descriptor on a miss. After that,
// block links the process in when the key already has a descriptor or takes
// a free one, peek and remove-head read the queue head, and remove-named
// reads the process's key before the lookup and walks the queue links after
// a hit until the process is met. The response register is then loaded. A
// process index out of range on block or remove-named goes straight to the
// response. A new request is taken in the cycle after a response is
// registered, even while that response is still stalled.
module semaphore_wait_queue_table #(
   parameter int MAX_PROCESSES = swq_pkg::DEF_MAX_PROCESSES,
   parameter int KEY_BITS      = swq_pkg::DEF_KEY_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  swq_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output swq_pkg::rsp_word_type rsp_data
);

   // command and status between controller and datapath
   swq_pkg::cmd_type  cmd;
   swq_pkg::stat_type stat;

   swq_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   swq_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .KEY_BITS      (KEY_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

FILE: sv/swq_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the semaphore wait queue table, with its bind.
module swq_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input swq_pkg::rsp_word_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   a_proc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.result_valid |-> rsp_data.result_proc == '0)
      else $error("result_proc nonzero without result_valid");

   a_valid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_valid |-> rsp_data.status == swq_pkg::ST_OK)
      else $error("process id returned with failing status");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind semaphore_wait_queue_table swq_checker u_swq_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
